// ----- sv/nfws_pkg.sv -----
// ----------------------------------------------------------------------------
// nfws_pkg : shared types and constants of the NOR flash word store
// Geometry, request and status codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package nfws_pkg;

  // Geometry
  localparam int SECTOR_BYTES     = 65536;
  localparam int NUM_SECTORS      = 20;
  localparam int WORDS_PER_SECTOR = SECTOR_BYTES / 2;
  localparam int TOTAL_WORDS      = WORDS_PER_SECTOR * NUM_SECTORS;
  localparam int MEM_AW           = $clog2(TOTAL_WORDS);

  // Field widths
  localparam int MODE_W   = 2;
  localparam int ADDR_W   = 21;
  localparam int DATA_W   = 16;
  localparam int SECTOR_W = 5;
  localparam int STATUS_W = 2;

  localparam int IN_FIELDS_W  = MODE_W + ADDR_W + DATA_W + SECTOR_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DATA_W + STATUS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [DATA_W-1:0] ERASED_WORD = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ        = 2'd0,
    MODE_PROGRAM     = 2'd1,
    MODE_ERASE_SECT  = 2'd2,
    MODE_ERASE_ALL   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_ADDR   = 2'd1,
    STATUS_BAD_SECTOR = 2'd2
  } status_t;

  // Class of an incoming request, decoded straight off the input beat
  typedef enum logic [1:0] {
    CLS_READ,
    CLS_PROGRAM,
    CLS_ERASE,
    CLS_REJECT
  } in_class_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_ERASE,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic accept;      // latch request, start word read, load walk bounds
    logic prog_write;  // write back read word ANDed with request data
    logic erase_step;  // write erased word at walk pointer and advance
    logic push;        // load the output register
    logic push_mem;    // output data comes from the memory read port
    logic hold_mem;    // park memory read data in the result register
  } cmd_t;

  typedef struct packed {
    in_class_t in_class;
    mode_t     req_mode;
    logic      walk_last;
    logic      out_free;
  } stat_t;

endpackage

// ----- sv/nfws_ram.sv -----
// ----------------------------------------------------------------------------
// nfws_ram : generic single-port RAM
// One address per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module nfws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/nfws_datapath.sv -----
// ----------------------------------------------------------------------------
// nfws_datapath : request registers, erase walker, word store, result path
// Decodes the input beat, runs the store and holds the output register.
// ----------------------------------------------------------------------------
module nfws_datapath import nfws_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  cmd_t                   cmd,
  output stat_t                  stat
);

  logic [MODE_W-1:0]   in_mode;
  logic [ADDR_W-1:0]   in_address;
  logic [DATA_W-1:0]   in_data;
  logic [SECTOR_W-1:0] in_sector;
  logic [MEM_AW-1:0]   in_idx;
  logic                in_addr_bad;
  logic                in_sector_bad;
  logic [MEM_AW-1:0]   in_base;
  status_t             in_status;
  in_class_t           in_class;

  mode_t               req_mode;
  logic [DATA_W-1:0]   req_data;
  logic [MEM_AW-1:0]   req_idx;
  logic [MEM_AW-1:0]   ptr;
  logic [MEM_AW-1:0]   last;
  logic [DATA_W-1:0]   res_data;
  status_t             res_status;
  logic [DATA_W-1:0]   out_data;
  status_t             out_status;

  logic [MEM_AW-1:0]   ram_addr;
  logic                ram_we;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   ram_rdata;

  assign in_mode    = in_tdata[MODE_W-1:0];
  assign in_address = in_tdata[MODE_W +: ADDR_W];
  assign in_data    = in_tdata[MODE_W+ADDR_W +: DATA_W];
  assign in_sector  = in_tdata[MODE_W+ADDR_W+DATA_W +: SECTOR_W];

  assign in_idx        = MEM_AW'(in_address[ADDR_W-1:1]);
  assign in_addr_bad   = in_address[0] ||
                         (32'(in_address[ADDR_W-1:1]) >= 32'(TOTAL_WORDS));
  assign in_sector_bad = 32'(in_sector) >= 32'(NUM_SECTORS);
  assign in_base       = MEM_AW'(32'(in_sector) * 32'(WORDS_PER_SECTOR));

  always_comb begin
    in_status = STATUS_OK;
    in_class  = CLS_ERASE;
    unique case (mode_t'(in_mode))
      MODE_READ: begin
        in_class  = in_addr_bad ? CLS_REJECT : CLS_READ;
        in_status = in_addr_bad ? STATUS_BAD_ADDR : STATUS_OK;
      end
      MODE_PROGRAM: begin
        in_class  = in_addr_bad ? CLS_REJECT : CLS_PROGRAM;
        in_status = in_addr_bad ? STATUS_BAD_ADDR : STATUS_OK;
      end
      MODE_ERASE_SECT: begin
        in_class  = in_sector_bad ? CLS_REJECT : CLS_ERASE;
        in_status = in_sector_bad ? STATUS_BAD_SECTOR : STATUS_OK;
      end
      MODE_ERASE_ALL: begin
        in_class  = CLS_ERASE;
        in_status = STATUS_OK;
      end
    endcase
  end

  // Request and result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode   <= mode_t'(in_mode);
      req_data   <= in_data;
      req_idx    <= in_idx;
      res_data   <= '0;
      res_status <= in_status;
    end else if (cmd.hold_mem) begin
      res_data   <= ram_rdata;
    end
  end

  // Erase walker: reset starts it over the whole store
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      last <= MEM_AW'(TOTAL_WORDS - 1);
    end else if (cmd.accept) begin
      if (mode_t'(in_mode) == MODE_ERASE_SECT) begin
        ptr  <= in_base;
        last <= in_base + MEM_AW'(WORDS_PER_SECTOR - 1);
      end else begin
        ptr  <= '0;
        last <= MEM_AW'(TOTAL_WORDS - 1);
      end
    end else if (cmd.erase_step) begin
      ptr <= ptr + MEM_AW'(1);
    end
  end

  always_comb begin
    ram_we    = cmd.erase_step || cmd.prog_write;
    ram_wdata = cmd.erase_step ? ERASED_WORD : (ram_rdata & req_data);
    if (cmd.accept) begin
      ram_addr = in_idx;
    end else if (cmd.erase_step) begin
      ram_addr = ptr;
    end else begin
      ram_addr = req_idx;
    end
  end

  nfws_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TOTAL_WORDS)
  ) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data   <= cmd.push_mem ? ram_rdata : res_data;
      out_status <= res_status;
    end
  end

  assign out_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_status, out_data};

  assign stat.in_class  = in_class;
  assign stat.req_mode  = req_mode;
  assign stat.walk_last = ptr == last;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ----- sv/nfws_ctrl.sv -----
// ----------------------------------------------------------------------------
// nfws_ctrl : request sequencer of the NOR flash word store
// Steps each request through access, erase walk and result hand-off.
// ----------------------------------------------------------------------------
module nfws_ctrl import nfws_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.walk_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (stat.in_class)
            CLS_READ, CLS_PROGRAM: state_next = ST_ACCESS;
            CLS_ERASE:             state_next = ST_ERASE;
            CLS_REJECT:            state_next = ST_PUSH;
          endcase
        end
      end
      ST_ACCESS: begin
        state_next = stat.out_free ? ST_IDLE : ST_PUSH;
      end
      ST_ERASE: begin
        if (stat.walk_last) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.erase_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_ACCESS: begin
        cmd.prog_write = stat.req_mode == MODE_PROGRAM;
        if (stat.out_free) begin
          cmd.push     = 1'b1;
          cmd.push_mem = stat.req_mode == MODE_READ;
        end else begin
          cmd.hold_mem = stat.req_mode == MODE_READ;
        end
      end
      ST_ERASE: begin
        cmd.erase_step = 1'b1;
      end
      ST_PUSH: begin
        cmd.push = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/nor_flash_word_store_core.sv -----
// ----------------------------------------------------------------------------
// nor_flash_word_store_core : sectored NOR flash store of 16-bit words
// Reads, programs (AND into the stored word) and erases sectors or the whole
// store, one request in and one result out per request.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents (lowest bit first)
//  -------  ---------  ---------------------------------------------------
//  s_*      in         mode[1:0], address[22:2], data[38:23], sector[43:39]
//  m_*      out        read_data[15:0], status[17:16]
//
//  Sequence: a read or program is accepted with its word read; then a program
//  writes the word back, and the result is loaded. A rejected request goes
//  straight to its result. A sector erase walks every word of the sector, an
//  erase-all every word of the store (655360), before its result is loaded.
//  Reset: rst is synchronous, active high; after it the store is swept to the
//  erased state, one word per cycle over all 655360 words, with s_tready low.
//  Stalls: a waiting result sits in the output register; the next request is
//  taken meanwhile and finishes into a hold register until the output frees.
// ----------------------------------------------------------------------------
module nor_flash_word_store_core import nfws_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // mode[1:0], address[22:2], data[38:23], sector[43:39], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // read_data[15:0], status[17:16], zero fill above
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence requests: clear pass, access, erase walk, result hand-off
  nfws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the request, walk erases, run the store, drive the result beat
  nfws_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_tdata  (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_tdata (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for nor_flash_word_store_core
// A queue of requests feeds a stream driver; each accepted beat is run
// through a behavioural flash image, and a monitor checks every result beat
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
  import nfws_pkg::*;

  // Byte addresses at the top of the store, and the largest value of each field
  localparam int unsigned LAST_WORD_ADDR = (TOTAL_WORDS - 1) * 2;
  localparam int unsigned END_ADDR       = TOTAL_WORDS * 2;
  localparam int unsigned ADDR_MAX       = (1 << ADDR_W) - 1;
  localparam int unsigned DATA_MAX       = (1 << DATA_W) - 1;
  localparam int unsigned SECTOR_MAX     = (1 << SECTOR_W) - 1;

  localparam int RANDOM_REQS  = 2000;
  localparam int POOL_SIZE    = 16;
  // Beat counts between which neither side idles
  localparam int CALM_FIRST   = 600;
  localparam int CALM_LAST    = 1000;

  typedef struct {
    mode_t                 mode;
    logic [ADDR_W-1:0]     address;
    logic [DATA_W-1:0]     data;
    logic [SECTOR_W-1:0]   sector;
    bit                    drain_first;  // hold off until all results are in
  } flash_req_t;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    status_t           status;
  } flash_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // mode[1:0], address[22:2], data[38:23], sector[43:39], zero fill above
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // read_data[15:0], status[17:16], zero fill above
  logic [OUT_TDATA_W-1:0] m_tdata;

  bit [DATA_W-1:0] flash_image [TOTAL_WORDS];
  flash_req_t      pending_reqs[$];
  flash_result_t   expected_results[$];
  flash_req_t      req_on_bus;
  flash_result_t   seen_result;
  flash_result_t   want_result;
  int unsigned     pool_words [POOL_SIZE];
  int              beats_sent   = 0;
  int              results_seen = 0;
  int              errors       = 0;

  nor_flash_word_store_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // Apply one request to the flash image and return the result it gives
  function automatic flash_result_t flash_apply(flash_req_t req);
    flash_result_t     res;
    logic [MEM_AW-1:0] word_idx;
    res.read_data = '0;
    res.status    = STATUS_OK;
    word_idx      = MEM_AW'(req.address[ADDR_W-1:1]);
    case (req.mode)
      MODE_READ, MODE_PROGRAM: begin
        // odd byte address or a word beyond the store is refused untouched
        if (req.address[0] || 32'(word_idx) >= TOTAL_WORDS) begin
          res.status = STATUS_BAD_ADDR;
        end else if (req.mode == MODE_READ) begin
          res.read_data = flash_image[word_idx];
        end else begin
          flash_image[word_idx] = flash_image[word_idx] & req.data;
        end
      end
      MODE_ERASE_SECT: begin
        if (32'(req.sector) >= NUM_SECTORS) begin
          res.status = STATUS_BAD_SECTOR;
        end else begin
          for (int i = 0; i < WORDS_PER_SECTOR; i++)
            flash_image[MEM_AW'(32'(req.sector) * WORDS_PER_SECTOR + i)] = ERASED_WORD;
        end
      end
      default: begin
        for (int i = 0; i < TOTAL_WORDS; i++) flash_image[MEM_AW'(i)] = ERASED_WORD;
      end
    endcase
    return res;
  endfunction

  task automatic queue_req(mode_t mode, int unsigned address, int unsigned data,
                           int unsigned sector, bit drain_first = 1'b0);
    flash_req_t req;
    req.mode        = mode;
    req.address     = ADDR_W'(address);
    req.data        = DATA_W'(data);
    req.sector      = SECTOR_W'(sector);
    req.drain_first = drain_first;
    pending_reqs.push_back(req);
  endtask

  // Driver: predict on acceptance, then load the next beat when the slot frees
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(flash_apply(req_on_bus));
        beats_sent++;
      end
      if (!s_tvalid || s_tready) begin
        // idle at random outside the calm stretch; hold a drain-first beat
        // back while any result is still owed
        if (pending_reqs.size() == 0 ||
            (!(beats_sent >= CALM_FIRST && beats_sent < CALM_LAST) &&
             $urandom_range(99) < 6) ||
            (pending_reqs[0].drain_first && expected_results.size() != 0)) begin
          s_tvalid <= 1'b0;
        end else begin
          req_on_bus = pending_reqs.pop_front();
          s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, req_on_bus.sector,
                       req_on_bus.data, req_on_bus.address, req_on_bus.mode};
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each result beat, then stall the next one at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_result.read_data = m_tdata[DATA_W-1:0];
        seen_result.status    = status_t'(m_tdata[DATA_W +: STATUS_W]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got read_data %h status %0d",
                   $time, seen_result.read_data, seen_result.status);
          errors++;
        end else begin
          want_result = expected_results.pop_front();
          if (seen_result.read_data !== want_result.read_data) begin
            $display("%0t: read_data mismatch, expected %h, got %h",
                     $time, want_result.read_data, seen_result.read_data);
            errors++;
          end
          if (seen_result.status !== want_result.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want_result.status, seen_result.status);
            errors++;
          end
        end
        results_seen++;
      end
      m_tready <= (results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                  ($urandom_range(99) >= 6);
    end
  end

  initial begin
    int unsigned sect;
    int unsigned address;
    int unsigned data;
    int unsigned sector;
    int unsigned roll;
    int unsigned pick;
    int          sector_erases_left;
    int          total_reqs;

    for (int i = 0; i < TOTAL_WORDS; i++) flash_image[MEM_AW'(i)] = ERASED_WORD;

    // Directed: corners of the store, each refusal and every operation
    queue_req(MODE_READ,       0,              0,        0);
    queue_req(MODE_PROGRAM,    0,              16'h1234, 0);
    queue_req(MODE_PROGRAM,    0,              16'hFF0F, SECTOR_MAX);
    queue_req(MODE_READ,       0,              DATA_MAX, SECTOR_MAX);
    queue_req(MODE_PROGRAM,    LAST_WORD_ADDR, 16'h0000, 0);
    queue_req(MODE_READ,       LAST_WORD_ADDR, 0,        0);
    queue_req(MODE_READ,       END_ADDR,       0,        0);
    queue_req(MODE_PROGRAM,    ADDR_MAX - 1,   16'h0000, 0);
    queue_req(MODE_READ,       ADDR_MAX,       0,        0);
    queue_req(MODE_PROGRAM,    1,              16'h0000, 0);
    queue_req(MODE_READ,       1,              DATA_MAX, SECTOR_MAX);
    queue_req(MODE_PROGRAM,    WORDS_PER_SECTOR * 2 - 2, 16'h00F0, 0);
    queue_req(MODE_PROGRAM,    WORDS_PER_SECTOR * 2,     16'h0F00, 0);
    queue_req(MODE_ERASE_SECT, ADDR_MAX,       DATA_MAX, 0);
    queue_req(MODE_READ,       0,              0,        0);
    queue_req(MODE_READ,       WORDS_PER_SECTOR * 2 - 2, 0, 0);
    queue_req(MODE_READ,       WORDS_PER_SECTOR * 2,     0, 0);
    queue_req(MODE_ERASE_SECT, 0,              0,        NUM_SECTORS - 1);
    queue_req(MODE_READ,       LAST_WORD_ADDR, 0,        0);
    queue_req(MODE_ERASE_SECT, 0,              0,        NUM_SECTORS);
    queue_req(MODE_ERASE_SECT, ADDR_MAX,       DATA_MAX, SECTOR_MAX);
    queue_req(MODE_ERASE_ALL,  ADDR_MAX,       DATA_MAX, 5, 1'b1);
    queue_req(MODE_READ,       WORDS_PER_SECTOR * 2,     0, 0);

    // Hot words near sector edges, so programs and reads keep meeting
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i % 4)
        0:       sect = 0;
        1:       sect = 1;
        2:       sect = NUM_SECTORS - 1;
        default: sect = $urandom_range(NUM_SECTORS - 1);
      endcase
      pool_words[i] = sect * WORDS_PER_SECTOR +
                      ($urandom_range(1) ? $urandom_range(3)
                                         : WORDS_PER_SECTOR - 1 - $urandom_range(3));
    end

    // Random: mostly hot-word traffic; in-range sector erases are rationed
    // since each one walks a whole sector
    sector_erases_left = 6;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      roll   = $urandom_range(99);
      pick   = $urandom_range(99);
      data   = $urandom_range(DATA_MAX);
      sector = $urandom_range(SECTOR_MAX);
      if (pick < 60)      address = pool_words[$urandom_range(POOL_SIZE - 1)] * 2;
      else if (pick < 75) address = pool_words[$urandom_range(POOL_SIZE - 1)] * 2 + 1;
      else                address = $urandom_range(ADDR_MAX);
      if (roll < 40) begin
        // set most bits half the time so stored words wear down slowly
        if ($urandom_range(1)) data = data | $urandom_range(DATA_MAX);
        queue_req(MODE_PROGRAM, address, data, sector, n == RANDOM_REQS / 2);
      end else if (roll < 82) begin
        queue_req(MODE_READ, address, data, sector, n == RANDOM_REQS / 2);
      end else begin
        if (sector_erases_left > 0 && $urandom_range(39) == 0) begin
          sector = pool_words[$urandom_range(POOL_SIZE - 1)] / WORDS_PER_SECTOR;
          sector_erases_left--;
        end else begin
          sector = $urandom_range(SECTOR_MAX, NUM_SECTORS);
        end
        queue_req(MODE_ERASE_SECT, address, data, sector, n == RANDOM_REQS / 2);
      end
    end
    total_reqs = pending_reqs.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Drain: every result in, then watch for strays
    while (results_seen < total_reqs) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog: covers the reset sweep, one full erase and the sector erases
  // several times over
  initial begin
    #96_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
